>>> hdl/pih_pkg.sv
`default_nettype none

package pih_pkg;

	// Default sizes for the top-level parameters.
	localparam int MAX_OPS_DEF    = 32;
	localparam int DATA_WIDTH_DEF = 64;

	// Fixed field widths of the ports.
	localparam int ENTRY_W    = 5;
	localparam int KIND_W     = 4;
	localparam int CONST_W    = 64;
	localparam int HASH_W     = 64;
	localparam int OP_COUNT_W = 6;
	localparam int NARROW_W   = 32;

	// Configuration port.
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 6;
	localparam logic [CFG_IDX_W-1:0] REG_WIDE_MODE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_OP_COUNT  = 1'b1;

	// Command codes.
	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_HASH = 1'b1;

	// The shift count of a constant is reduced one nibble per cycle on load.
	localparam int DIGIT_W      = 4;
	localparam int LOAD_DIGITS  = CONST_W / DIGIT_W;
	localparam int DIGIT_CNT_W  = $clog2(LOAD_DIGITS);

	typedef enum logic [KIND_W-1:0] {
		OP_XOR    = 4'd0,
		OP_MUL    = 4'd1,
		OP_ADD    = 4'd2,
		OP_ROTL   = 4'd3,
		OP_NOT    = 4'd4,
		OP_XORSHL = 4'd5,
		OP_XORSHR = 4'd6,
		OP_ADDSHL = 4'd7,
		OP_SUBSHL = 4'd8
	} op_kind_t;

	// Partial products of a wide multiply: low x low, low x high, high x low.
	typedef enum logic [1:0] {
		PH_LL,
		PH_LH,
		PH_HL
	} mul_phase_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_HASH
	} state_t;

	// Control handed from the sequencer to the operation unit.
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic              wide;
		mul_phase_t        phase;
	} op_ctl_t;

endpackage

`default_nettype wire

>>> hdl/pih_alu.sv
`default_nettype none

module pih_alu import pih_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	localparam int SW = $clog2(DATA_WIDTH)
) (
	input  var op_ctl_t         ctl,
	input  wire [DATA_WIDTH-1:0] x,
	input  wire [DATA_WIDTH-1:0] k,
	input  wire [SW-1:0]         shamt,
	input  wire [63:0]           acc,
	output logic [DATA_WIDTH-1:0] res,
	output logic [63:0]          acc_nxt
);

	logic [DATA_WIDTH-1:0] m;
	logic [DATA_WIDTH-1:0] sl;
	logic [DATA_WIDTH-1:0] sr;
	logic [DATA_WIDTH-1:0] r;
	logic [SW:0]           wv;
	logic [SW:0]           ramt;
	logic [63:0]           xp;
	logic [63:0]           kp;
	logic [63:0]           prod;
	logic [31:0]           ma;
	logic [31:0]           mb;

	// Working width mask, and the shared left and right shifters.
	// A rotate takes its right half from the right shifter by the width less the count.
	always_comb begin
		m    = ctl.wide ? '1 : DATA_WIDTH'({NARROW_W{1'b1}});
		wv   = ctl.wide ? (SW+1)'(DATA_WIDTH) : (SW+1)'(NARROW_W);
		ramt = (ctl.kind == OP_ROTL) ? (wv - {1'b0, shamt}) : {1'b0, shamt};
		sl   = (x << shamt) & m;
		sr   = x >> ramt;
	end

	// One 32 by 32 multiplier, stepped through the partial products of a wide multiply.
	always_comb begin
		xp = 64'(x);
		kp = 64'(k);
		case (ctl.phase)
			PH_LL: begin
				ma = xp[31:0];
				mb = kp[31:0];
			end
			PH_LH: begin
				ma = xp[31:0];
				mb = kp[63:32];
			end
			PH_HL: begin
				ma = xp[63:32];
				mb = kp[31:0];
			end
			default: begin
				ma = xp[31:0];
				mb = kp[31:0];
			end
		endcase
		prod = 64'(ma) * 64'(mb);
		if (ctl.phase == PH_LL) begin
			acc_nxt = prod;
		end else begin
			acc_nxt = acc + {prod[31:0], 32'b0};
		end
	end

	// Operation select; unused kinds leave the value as it is.
	always_comb begin
		case (ctl.kind)
			OP_XOR:    r = x ^ k;
			OP_MUL:    r = acc_nxt[DATA_WIDTH-1:0];
			OP_ADD:    r = x + k;
			OP_ROTL:   r = sl | sr;
			OP_NOT:    r = ~x;
			OP_XORSHL: r = x ^ sl;
			OP_XORSHR: r = x ^ sr;
			OP_ADDSHL: r = x + sl;
			OP_SUBSHL: r = x - sl;
			default:   r = x;
		endcase
		res = r & m;
	end

endmodule

`default_nettype wire

>>> hdl/programmable_integer_hash.sv
`default_nettype none

// Programmable integer hash engine.
// Commands are taken on start while busy is low. A load command (func 0) writes one
// entry of the operation table: op_kind and op_constant at entry_index. Loads to an
// index at or above MAX_OPS are dropped at once; others keep busy high while the shift
// count of the constant is reduced one nibble a cycle. A hash command (func 1) runs
// data_in through table entries 0 to op_count-1 (op_count limited to MAX_OPS) at one
// entry a cycle, save while a wide multiply is under way, through a single shared
// operation unit, fed from the table memory with one entry read ahead. A multiply in
// 64-bit mode builds its product from three passes through one 32 by 32 multiplier.
// The result transaction appears on hash_out with done high for one cycle after the
// last step, and a new command may be accepted in that same cycle. With op_count zero,
// done follows in the cycle after accept.
// The receiver cannot stall: each result is valid for its one strobe cycle only.
// The configuration port writes wide_mode and op_count; the user must write them only
// while the engine is idle, which the block itself does not enforce.
// Reset clears the sequencer and both registers; table contents are undefined until
// loaded.

module programmable_integer_hash import pih_pkg::*; #(
	parameter int MAX_OPS    = MAX_OPS_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  start,
	output logic                 busy,
	input  wire                  func,
	input  wire [ENTRY_W-1:0]    entry_index,
	input  wire [KIND_W-1:0]     op_kind,
	input  wire [CONST_W-1:0]    op_constant,
	input  wire [CONST_W-1:0]    data_in,
	output logic                 done,
	output logic [HASH_W-1:0]    hash_out,
	input  wire                  cfg_we,
	input  wire [CFG_IDX_W-1:0]  cfg_index,
	input  wire [CFG_DATA_W-1:0] cfg_data
);

	localparam int  IDX_W    = (MAX_OPS > 1) ? $clog2(MAX_OPS) : 1;
	localparam int  CNT_W    = $clog2(MAX_OPS + 1);
	localparam int  SW       = $clog2(DATA_WIDTH);
	localparam int  TW       = SW + DIGIT_W;
	localparam bit  WIDE_MUL = (DATA_WIDTH > NARROW_W);
	localparam logic [TW-1:0] W_T = TW'(DATA_WIDTH);

	state_t state_q;
	state_t state_nxt;

	logic                   wide_mode_q;
	logic [OP_COUNT_W-1:0]  op_count_q;

	logic [DATA_WIDTH-1:0]  x_q;
	logic [63:0]            acc_q;
	mul_phase_t             phase_q;
	logic [IDX_W-1:0]       cnt_q;
	logic [CNT_W-1:0]       n_q;
	logic                   done_q;
	logic [HASH_W-1:0]      hash_q;

	logic [IDX_W-1:0]       ld_idx_q;
	logic [KIND_W-1:0]      ld_kind_q;
	logic [DATA_WIDTH-1:0]  ld_k_q;
	logic [CONST_W-1:0]     ld_sh_q;
	logic [SW-1:0]          ld_rem_q;
	logic [DIGIT_CNT_W-1:0] digit_q;

	logic [KIND_W-1:0]      kind_mem  [MAX_OPS];
	logic [DATA_WIDTH-1:0]  const_mem [MAX_OPS];
	logic [SW-1:0]          shamt_mem [MAX_OPS];
	logic [KIND_W-1:0]      kind_rd_q;
	logic [DATA_WIDTH-1:0]  const_rd_q;
	logic [SW-1:0]          shamt_rd_q;

	logic                   accept;
	logic                   in_range;
	logic [CNT_W-1:0]       n_sat;
	logic [DATA_WIDTH-1:0]  mask_w;
	logic [DATA_WIDTH-1:0]  x_in;
	logic [CNT_W-1:0]       cnt_nxt;
	logic                   op_done;
	logic                   last_digit;
	logic                   rd_en;
	logic [IDX_W-1:0]       rd_addr;
	logic                   mem_we;
	logic [TW-1:0]          rem_t;
	logic [SW-1:0]          rem_nxt;
	logic [SW-1:0]          shamt_sel;
	op_ctl_t                ctl;
	logic [DATA_WIDTH-1:0]  alu_res;
	logic [63:0]            alu_acc;

	// Command decode and the values latched at accept.
	always_comb begin
		accept   = start && (state_q == ST_IDLE);
		in_range = {2'b00, entry_index} < 7'(MAX_OPS);
		if ({1'b0, op_count_q} > 7'(MAX_OPS)) begin
			n_sat = CNT_W'(MAX_OPS);
		end else begin
			n_sat = CNT_W'(op_count_q);
		end
		mask_w = wide_mode_q ? '1 : DATA_WIDTH'({NARROW_W{1'b1}});
		x_in   = data_in[DATA_WIDTH-1:0] & mask_w;
	end

	// Step bookkeeping: a wide multiply ends on its third partial product.
	always_comb begin
		cnt_nxt    = CNT_W'(cnt_q) + CNT_W'(1);
		op_done    = !((kind_rd_q == OP_MUL) && wide_mode_q && WIDE_MUL && (phase_q != PH_HL));
		last_digit = (digit_q == DIGIT_CNT_W'(LOAD_DIGITS - 1));
	end

	// Shift count modulo the wide width: bring in one nibble and restore by 8W, 4W, 2W, W.
	always_comb begin
		rem_t = {ld_rem_q, ld_sh_q[CONST_W-1 -: DIGIT_W]};
		for (int j = DIGIT_W - 1; j >= 0; j--) begin
			if (rem_t >= (W_T << j)) begin
				rem_t = rem_t - (W_T << j);
			end
		end
		rem_nxt = rem_t[SW-1:0];
	end

	// Next state.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && (func == FUNC_LOAD) && in_range) begin
					state_nxt = ST_LOAD;
				end else if (accept && (func == FUNC_HASH) && (n_sat != '0)) begin
					state_nxt = ST_HASH;
				end
			end
			ST_LOAD: begin
				if (last_digit) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_HASH: begin
				if (op_done && (cnt_nxt == n_q)) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// Sequencer outputs: handshake, table read-ahead and table write.
	always_comb begin
		busy    = 1'b1;
		rd_en   = 1'b0;
		rd_addr = '0;
		mem_we  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				busy  = 1'b0;
				rd_en = 1'b1;
			end
			ST_LOAD: begin
				mem_we = last_digit;
			end
			ST_HASH: begin
				rd_en   = op_done;
				rd_addr = cnt_nxt[IDX_W-1:0];
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wide_mode_q <= 1'b0;
			op_count_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WIDE_MODE: wide_mode_q <= cfg_data[0];
				REG_OP_COUNT:  op_count_q  <= OP_COUNT_W'(cfg_data);
				default:       wide_mode_q <= wide_mode_q;
			endcase
		end
	end

	// Result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (accept && (func == FUNC_HASH) && (n_sat == '0))
				|| ((state_q == ST_HASH) && op_done && (cnt_nxt == n_q));
		end
	end

	// Working value, multiply accumulator and step counters.
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q     <= x_in;
			n_q     <= n_sat;
			cnt_q   <= '0;
			phase_q <= PH_LL;
			hash_q  <= HASH_W'(x_in);
		end else if (state_q == ST_HASH) begin
			acc_q <= alu_acc;
			if (op_done) begin
				x_q     <= alu_res;
				cnt_q   <= cnt_nxt[IDX_W-1:0];
				phase_q <= PH_LL;
				hash_q  <= HASH_W'(alu_res);
			end else begin
				case (phase_q)
					PH_LL:   phase_q <= PH_LH;
					PH_LH:   phase_q <= PH_HL;
					default: phase_q <= PH_LL;
				endcase
			end
		end
	end

	// Load sequence: latch the entry, then reduce its shift count nibble by nibble.
	always_ff @(posedge clk) begin
		if (accept) begin
			ld_idx_q  <= IDX_W'(entry_index);
			ld_kind_q <= op_kind;
			ld_k_q    <= op_constant[DATA_WIDTH-1:0];
			ld_sh_q   <= op_constant;
			ld_rem_q  <= '0;
			digit_q   <= '0;
		end else if (state_q == ST_LOAD) begin
			ld_sh_q  <= ld_sh_q << DIGIT_W;
			ld_rem_q <= rem_nxt;
			digit_q  <= digit_q + DIGIT_CNT_W'(1);
		end
	end

	// Operation table memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			kind_mem[ld_idx_q]  <= ld_kind_q;
			const_mem[ld_idx_q] <= ld_k_q;
			shamt_mem[ld_idx_q] <= rem_nxt;
		end
		if (rd_en) begin
			kind_rd_q  <= kind_mem[rd_addr];
			const_rd_q <= const_mem[rd_addr];
			shamt_rd_q <= shamt_mem[rd_addr];
		end
	end

	// In 32-bit mode the count is the constant modulo 32, its low five bits.
	always_comb begin
		shamt_sel = wide_mode_q ? shamt_rd_q : SW'(const_rd_q[4:0]);
		ctl.kind  = kind_rd_q;
		ctl.wide  = wide_mode_q;
		ctl.phase = phase_q;
	end

	pih_alu #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_alu (
		.ctl     (ctl),
		.x       (x_q),
		.k       (const_rd_q),
		.shamt   (shamt_sel),
		.acc     (acc_q),
		.res     (alu_res),
		.acc_nxt (alu_acc)
	);

	assign done     = done_q;
	assign hash_out = hash_q;

endmodule

`default_nettype wire
